// ----- rtl/cqs_pkg.sv -----
// shared types, constants and helpers for the circular queue with search
package cqs_pkg;

    // ring size and derived widths
    localparam int DEPTH   = 16;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_MAX = 15;

    typedef logic [PTR_W-1:0] t_ptr;

    // command codes
    typedef enum logic [2:0] {
        CMD_ENQ      = 3'd0,
        CMD_DEQ      = 3'd1,
        CMD_PEEK     = 3'd2,
        CMD_CONTAINS = 3'd3,
        CMD_OCCUPIED = 3'd4,
        CMD_COUNT    = 3'd5,
        CMD_CLEAR    = 3'd6
    } t_cmd;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // one input item
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
        logic [3:0]         slot_index;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic signed [31:0] data;
        logic               flag;
        logic [3:0]         count;
        t_status            status;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
        logic take;
        logic step;
    } t_dp_ctl;

    // datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic empty;
        logic match;
        logic last;
    } t_dp_sts;

    // advance a ring position with wrap
    function automatic t_ptr next_pos(input t_ptr p);
        if (32'(p) == DEPTH - 1) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

endpackage

// ----- rtl/cqs_datapath.sv -----
// datapath: slot memory, head and tail pointers, search walker and result registers
module cqs_datapath
    import cqs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_ctl   i_ctl,
    output t_dp_sts   o_sts,
    output t_out_item o_result
);

    logic signed [31:0] mem [DEPTH];

    t_in_item           r_item;
    t_ptr               r_head, n_head;
    t_ptr               r_tail, n_tail;
    t_ptr               r_ptr;
    logic signed [31:0] r_rdata;
    logic signed [31:0] r_data;
    logic               r_flag;
    t_status            r_status;

    t_cmd        cmd;
    logic        empty;
    logic        full;
    logic        occ;
    logic        wr_en;
    t_ptr        rd_addr;
    t_ptr        ptr_next;
    logic [31:0] idx32;
    logic [31:0] cnt32;

    assign cmd      = t_cmd'(r_item.cmd);
    assign empty    = (r_head == r_tail);
    assign full     = (next_pos(r_tail) == r_head);
    assign ptr_next = next_pos(r_ptr);
    assign idx32    = 32'(r_item.slot_index);

    // raw slot index inside the occupied region
    always_comb begin
        if (idx32 >= DEPTH || empty) begin
            occ = 1'b0;
        end else if (r_head < r_tail) begin
            occ = (idx32 >= 32'(r_head)) && (idx32 < 32'(r_tail));
        end else begin
            occ = (idx32 < 32'(r_tail)) || (idx32 >= 32'(r_head));
        end
    end

    // slot memory, one write and one registered read per cycle
    assign wr_en   = i_ctl.exec && (cmd == CMD_ENQ) && !full;
    assign rd_addr = i_ctl.exec ? r_head : ptr_next;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= r_item.value;
        end
        r_rdata <= mem[rd_addr];
    end

    // pointer updates
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.exec) begin
            if (wr_en) begin
                n_tail = next_pos(r_tail);
            end
            if (cmd == CMD_CLEAR) begin
                n_head = '0;
                n_tail = '0;
            end
        end
        if (i_ctl.take && cmd == CMD_DEQ) begin
            n_head = next_pos(r_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // item latch, walker and result fields
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_item <= i_item;
        end
        if (i_ctl.exec) begin
            r_ptr  <= r_head;
            r_data <= '0;
            r_flag <= (cmd == CMD_OCCUPIED) && occ;
            case (cmd) inside
                CMD_ENQ: begin
                    r_status <= full ? ST_FULL : ST_OK;
                end
                CMD_DEQ, CMD_PEEK: begin
                    r_status <= empty ? ST_EMPTY : ST_OK;
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end
        if (i_ctl.take) begin
            r_data <= r_rdata;
        end
        if (i_ctl.step) begin
            r_ptr <= ptr_next;
            if (r_rdata == r_item.value) begin
                r_flag <= 1'b1;
            end
        end
    end

    // status back to the controller
    assign o_sts.cmd   = cmd;
    assign o_sts.empty = empty;
    assign o_sts.match = (r_rdata == r_item.value);
    assign o_sts.last  = (ptr_next == r_tail);

    // stored words, saturated to the field
    always_comb begin
        if (r_head <= r_tail) begin
            cnt32 = 32'(r_tail) - 32'(r_head);
        end else begin
            cnt32 = DEPTH - (32'(r_head) - 32'(r_tail));
        end
    end

    assign o_result.data   = r_data;
    assign o_result.flag   = r_flag;
    assign o_result.count  = (cnt32 > CNT_MAX) ? 4'(CNT_MAX) : 4'(cnt32);
    assign o_result.status = r_status;

endmodule

// ----- rtl/cqs_ctrl.sv -----
// controller: command sequencing state machine
module cqs_ctrl
    import cqs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_ctl o_ctl,
    output logic    o_busy,
    output logic    o_done
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_READ   = 5'b00100,
        S_SEARCH = 5'b01000,
        S_RESP   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                unique case (i_sts.cmd) inside
                    CMD_DEQ, CMD_PEEK: begin
                        n_state = i_sts.empty ? S_RESP : S_READ;
                    end
                    CMD_CONTAINS: begin
                        n_state = i_sts.empty ? S_RESP : S_SEARCH;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_READ: begin
                o_ctl.take = 1'b1;
                n_state    = S_RESP;
            end
            S_SEARCH: begin
                o_ctl.step = 1'b1;
                if (i_sts.match || i_sts.last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

endmodule

// ----- rtl/circular_queue_with_search_top.sv -----
// top level of the ring-buffer queue with value search
//
//  channel   ports                      handshake
//  command   start, i_item              taken when start high and busy low
//  result    o_done, o_result           o_done high for one cycle per item
//
// an accepted item passes the exec and resp states before the next acceptance; dequeue and
// peek on a non-empty queue also pass the read state, for the registered slot memory read.
// contains stays in the search state over n slots compared (1 to DEPTH-1),
// one memory read and compare per cycle from head towards tail.
// synchronous active-low reset empties the queue; slot contents are not cleared.
// the result cannot be stalled: it is valid only in the o_done cycle.
module circular_queue_with_search_top
    import cqs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_done,
    output t_out_item o_result
);

    t_dp_ctl ctl;
    t_dp_sts sts;

    // sequencing
    cqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // storage and result
    cqs_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_result (o_result)
    );

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("block not idle after result");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_FULL |-> o_result.count == 4'(CNT_MAX))
        else $error("full status with wrong count");

    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == ST_EMPTY |->
            o_result.count == 4'd0 && o_result.data == '0)
        else $error("empty status with stored words or data");

endmodule
